[src/qnao_pkg.sv]
`timescale 1ns / 1ps

package qnao_pkg;

	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 4;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_K     = 3'd0;
	localparam reg_idx_t REG_VR    = 3'd1;
	localparam reg_idx_t REG_VT    = 3'd2;
	localparam reg_idx_t REG_VPEAK = 3'd3;
	localparam reg_idx_t REG_A     = 3'd4;
	localparam reg_idx_t REG_B     = 3'd5;
	localparam reg_idx_t REG_C     = 3'd6;
	localparam reg_idx_t REG_D     = 3'd7;

	localparam logic signed [31:0] CFG_RESET [NUM_CFG] = '{
		32'sd45875, -32'sd3932160, -32'sd2621440, 32'sd2293760,
		32'sd1966, -32'sd131072, -32'sd3276800, 32'sd6553600
	};

	// Euler's number in Q2.30, summed from truncated Taylor terms.
	localparam logic [63:0] E_Q30 = 64'd2918732883;

	// Width of the Euler drive term and of the divider that scales it.
	localparam int DRV_W     = 36;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = DRV_W / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

	// Spike history bits summed per cycle.
	localparam int CHUNK   = 8;
	localparam int CHUNK_W = 3;

	typedef logic [2:0] op_t;

	localparam op_t OP_NONE  = 3'd0;
	localparam op_t OP_DRDT  = 3'd1;
	localparam op_t OP_KQ    = 3'd2;
	localparam op_t OP_BDR   = 3'd3;
	localparam op_t OP_INNER = 3'd4;
	localparam op_t OP_AIN   = 3'd5;
	localparam op_t OP_UN    = 3'd6;

	typedef struct packed {
		logic load;
		op_t  op;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic acc_busy;
	} status_t;

	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Q15.16 product: floor shift by 16, then saturate.
	function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> 16;
		return sat32(s);
	endfunction

endpackage

[src/qnao_ctrl.sv]
`timescale 1ns / 1ps

module qnao_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  qnao_pkg::status_t status,
	output qnao_pkg::cmd_t    cmd
);
	import qnao_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0] state_q;
	op_t        op_q;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load   = s_tvalid && s_tready;
		cmd.op     = (state_q == ST_MUL) ? op_q : OP_NONE;
		cmd.commit = (state_q == ST_WAIT) && !status.div_busy && !status.acc_busy &&
			(!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_MUL;
						op_q    <= OP_DRDT;
					end
				end
				ST_MUL: begin
					if (op_q == OP_UN) begin
						state_q <= ST_WAIT;
						op_q    <= OP_NONE;
					end else begin
						op_q <= op_q + 3'd1;
					end
				end
				ST_WAIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= OP_NONE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> status.acc_busy)
		else $error("alpha sum did not start after a transaction was accepted");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid && s_tready)
		else $error("commit did not present a result and return to idle");

	a_idle_no_divide: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !status.div_busy)
		else $error("divider busy while the block is idle");

	a_divider_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INNER) |=> status.div_busy)
		else $error("divider did not start on schedule");

endmodule

[src/qnao_datapath.sv]
`timescale 1ns / 1ps

module qnao_datapath #(
	parameter int ALPHA_BASE       = 4,
	parameter int MAX_AGE          = 40,
	parameter int CAPACITANCE      = 100,
	parameter int BASELINE_CURRENT = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [qnao_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic signed [31:0]              input_current,
	input  logic signed [31:0]              noise_sample,
	input  qnao_pkg::cmd_t                  cmd,
	output qnao_pkg::status_t               status,
	output logic signed [31:0]              membrane,
	output logic signed [31:0]              recovery,
	output logic                            spiked,
	output logic [31:0]                     alpha_output
);
	import qnao_pkg::*;

	localparam int HIST_BITS = MAX_AGE + 1;
	localparam int NCH       = (HIST_BITS + CHUNK - 1) / CHUNK;
	localparam int CNT_W     = $clog2(NCH);
	localparam int PAD       = NCH * CHUNK;
	localparam int PAD_W     = CNT_W + CHUNK_W;
	localparam int ACC_W     = 32 + PAD_W;
	localparam int CAP_W     = $clog2(CAPACITANCE + 1);

	localparam logic [CAP_W:0] CAP_DIV = (CAP_W + 1)'(CAPACITANCE);
	localparam logic signed [DRV_W-1:0] BASE_EXT = DRV_W'(BASELINE_CURRENT);

	typedef logic [31:0] rom_t [PAD];

	function automatic rom_t build_rom();
		rom_t rom;
		logic [63:0] g;
		logic [63:0] t;
		logic [63:0] w;
		logic [63:0] x;
		g = 64'd0;
		t = 64'd1 << 30;
		for (int j = 0; j <= 20; j++) begin
			if ((j % 2) != 0) begin
				g = g - t;
			end else begin
				g = g + t;
			end
			t = t / 64'(j + 1) / 64'(ALPHA_BASE);
		end
		w = E_Q30;
		for (int n = 0; n < PAD; n++) begin
			if (n > 0) begin
				w = (w * g) >> 30;
			end
			x = 64'(n) * w / 64'(ALPHA_BASE) + 64'd8192;
			rom[n] = (n < HIST_BITS) ? 32'(x >> 14) : 32'd0;
		end
		return rom;
	endfunction

	localparam rom_t KERNEL = build_rom();

	logic signed [31:0]       cfg_q [NUM_CFG];
	logic signed [31:0]       vp_q;
	logic signed [31:0]       u_q;
	logic [HIST_BITS-1:0]     hist_q;
	logic [DIV_CW-1:0]        div_cnt_q;
	logic                     acc_busy_q;
	logic [CNT_W-1:0]         acc_cnt_q;
	logic [ACC_W-1:0]         acc_q;

	logic signed [31:0]       dr_q;
	logic signed [31:0]       dt_q;
	logic signed [DRV_W-1:0]  base_q;
	logic signed [DRV_W-1:0]  drive_q;
	logic signed [31:0]       inner_q;
	logic signed [31:0]       un_q;
	logic signed [63:0]       prod_q;
	logic                     div_neg_q;
	logic [DRV_W-1:0]         div_sh_q;
	logic [CAP_W-1:0]         rem_q;

	logic signed [31:0]       mul_a;
	logic signed [31:0]       mul_b;
	logic signed [63:0]       mul_p;
	logic [DRV_W-1:0]         div_sh_n;
	logic [CAP_W-1:0]         rem_n;
	logic [PAD-1:0]           hist_pad;
	logic [ACC_W-1:0]         chunk;
	logic signed [DRV_W:0]    quot;
	logic signed [DRV_W+1:0]  v_wide;
	logic signed [31:0]       v_new;
	logic                     spike;
	logic signed [31:0]       u_new;

	assign status.div_busy = (div_cnt_q != '0);
	assign status.acc_busy = acc_busy_q;

	always_comb begin
		unique case (cmd.op)
			OP_DRDT: begin
				mul_a = dr_q;
				mul_b = dt_q;
			end
			OP_KQ: begin
				mul_a = cfg_q[REG_K];
				mul_b = qfix(prod_q);
			end
			OP_BDR: begin
				mul_a = cfg_q[REG_B];
				mul_b = dr_q;
			end
			default: begin
				mul_a = cfg_q[REG_A];
				mul_b = inner_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Restoring division by the capacitance, DIV_BITS quotient bits per cycle.
	always_comb begin
		logic [CAP_W:0] t;
		div_sh_n = div_sh_q;
		rem_n    = rem_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t        = {rem_n, div_sh_n[DRV_W-1]};
			div_sh_n = div_sh_n << 1;
			if (t >= CAP_DIV) begin
				t           = t - CAP_DIV;
				div_sh_n[0] = 1'b1;
			end
			rem_n = t[CAP_W-1:0];
		end
	end

	assign hist_pad = PAD'(hist_q);

	always_comb begin
		logic [PAD_W-1:0] idx;
		chunk = '0;
		for (int j = 0; j < CHUNK; j++) begin
			idx = {acc_cnt_q, CHUNK_W'(j)};
			if (hist_pad[idx]) begin
				chunk = chunk + ACC_W'(KERNEL[idx]);
			end
		end
	end

	always_comb begin
		quot   = div_neg_q ? -$signed({1'b0, div_sh_q}) : $signed({1'b0, div_sh_q});
		v_wide = (DRV_W + 2)'(vp_q) + (DRV_W + 2)'(quot);
		v_new  = sat32(64'(v_wide));
		spike  = (v_new >= cfg_q[REG_VPEAK]);
		u_new  = spike ? sat32(64'(un_q) + 64'(cfg_q[REG_D])) : un_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
			vp_q       <= CFG_RESET[REG_C];
			u_q        <= CFG_RESET[REG_D];
			hist_q     <= '0;
			div_cnt_q  <= '0;
			acc_busy_q <= 1'b0;
			acc_cnt_q  <= '0;
		end else begin
			if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
				cfg_q[cfg_index[2:0]] <= cfg_data;
			end
			if (cmd.load) begin
				acc_busy_q <= 1'b1;
				acc_cnt_q  <= '0;
			end else if (acc_busy_q) begin
				if (acc_cnt_q == CNT_W'(NCH - 1)) begin
					acc_busy_q <= 1'b0;
				end else begin
					acc_cnt_q <= acc_cnt_q + 1'b1;
				end
			end
			if (cmd.op == OP_INNER) begin
				div_cnt_q <= DIV_CW'(DIV_STEPS);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.commit) begin
				vp_q   <= spike ? cfg_q[REG_C] : v_new;
				u_q    <= u_new;
				hist_q <= {hist_q[HIST_BITS-2:0] | {{(HIST_BITS - 2){1'b0}}, spike}, 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dr_q   <= sat32(64'(vp_q) - 64'(cfg_q[REG_VR]));
			dt_q   <= sat32(64'(vp_q) - 64'(cfg_q[REG_VT]));
			base_q <= DRV_W'(input_current) + DRV_W'(noise_sample) + BASE_EXT - DRV_W'(u_q);
			acc_q  <= '0;
		end else if (acc_busy_q) begin
			acc_q <= acc_q + chunk;
		end
		if (cmd.op == OP_DRDT || cmd.op == OP_KQ || cmd.op == OP_BDR || cmd.op == OP_AIN) begin
			prod_q <= mul_p;
		end
		if (cmd.op == OP_BDR) begin
			drive_q <= base_q + DRV_W'(qfix(prod_q));
		end
		if (cmd.op == OP_INNER) begin
			inner_q   <= sat32(64'(qfix(prod_q)) - 64'(u_q));
			div_neg_q <= drive_q[DRV_W-1];
			div_sh_q  <= drive_q[DRV_W-1] ? DRV_W'(-drive_q) : DRV_W'(drive_q);
			rem_q     <= '0;
		end else if (div_cnt_q != '0) begin
			div_sh_q <= div_sh_n;
			rem_q    <= rem_n;
		end
		if (cmd.op == OP_UN) begin
			un_q <= sat32(64'(u_q) + 64'(qfix(prod_q)));
		end
		if (cmd.commit) begin
			membrane     <= v_new;
			recovery     <= u_new;
			spiked       <= spike;
			alpha_output <= (acc_q > ACC_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc_q[31:0];
		end
	end

endmodule

[src/quadratic_neuron_alpha_output.sv]
`timescale 1ns / 1ps
// Channel    Direction  Width  Contents
// s_axis     in         64     input_current, noise_sample
// m_axis     out        96+1   membrane, recovery, alpha_output; tuser spiked
// cfg        in         4+32   register index, write data
//
// A transaction runs the multiplies DRDT, KQ, BDR, INNER, AIN and UN in turn on
// the shared 32x32 multiplier; AIN and UN overlap the 4-bit-per-cycle divide by
// CAPACITANCE, which starts after INNER. The alpha sum runs alongside; the block
// then waits for the divide and the sum, commits the result and returns to idle.
// Reset clears the neuron to the reset potential and recovery jump values.
// A finished result waits in the output register while the next transaction is
// accepted; a stalled output delays only the commit of that next result.

module quadratic_neuron_alpha_output #(
	parameter int ALPHA_BASE       = 4,
	parameter int MAX_AGE          = 40,
	parameter int CAPACITANCE      = 100,
	parameter int BASELINE_CURRENT = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// input_current [31:0], noise_sample [63:32]
	input  logic [63:0]                     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// membrane [31:0], recovery [63:32], alpha_output [95:64]
	output logic [95:0]                     m_axis_tdata,
	// spiked [0]
	output logic [0:0]                      m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qnao_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import qnao_pkg::*;

	cmd_t               cmd;
	status_t            status;
	logic signed [31:0] membrane;
	logic signed [31:0] recovery;
	logic               spiked;
	logic [31:0]        alpha_output;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {alpha_output, recovery, membrane};
	assign m_axis_tuser = spiked;

	qnao_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	qnao_datapath #(
		.ALPHA_BASE       (ALPHA_BASE),
		.MAX_AGE          (MAX_AGE),
		.CAPACITANCE      (CAPACITANCE),
		.BASELINE_CURRENT (BASELINE_CURRENT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.input_current (s_axis_tdata[31:0]),
		.noise_sample  (s_axis_tdata[63:32]),
		.cmd           (cmd),
		.status        (status),
		.membrane      (membrane),
		.recovery      (recovery),
		.spiked        (spiked),
		.alpha_output  (alpha_output)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import qnao_pkg::*;

	localparam int ALPHA_BASE       = 4;
	localparam int MAX_AGE          = 40;
	localparam int CAPACITANCE      = 100;
	localparam int BASELINE_CURRENT = 0;

	localparam longint Q30_ONE     = 64'sd1 << 30;
	localparam int     CYCLE_LIMIT = 600000;
	localparam int     SETTLE      = 40;
	localparam int     CALM_SPAN   = 3000;
	localparam int     PHASES      = 12;
	localparam int     PHASE_TICKS = 153;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(NUM_CFG);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic signed [31:0] membrane;
		logic signed [31:0] recovery;
		logic               spiked;
		logic [31:0]        alpha;
	} tick_t;

	class tick_scoreboard;
		int                 errors;
		logic signed [31:0] cfg [NUM_CFG];
		logic signed [31:0] potential;
		logic signed [31:0] recovery;
		logic [MAX_AGE:0]   ages;
		longint unsigned    kernel [MAX_AGE+1];
		tick_t              expected_ticks [$];

		function new();
			longint e;
			longint g;
			longint t;
			longint w;
			errors = 0;
			foreach (cfg[i]) cfg[i] = CFG_RESET[i];
			potential = CFG_RESET[REG_C];
			recovery = CFG_RESET[REG_D];
			ages = '0;
			e = 0;
			g = 0;
			t = Q30_ONE;
			for (int j = 0; j <= 20; j++) begin
				e += t;
				t = t / (j + 1);
			end
			t = Q30_ONE;
			for (int j = 0; j <= 20; j++) begin
				if (j % 2 == 1) begin
					g -= t;
				end else begin
					g += t;
				end
				t = t / (longint'(j + 1) * ALPHA_BASE);
			end
			w = e;
			for (int n = 0; n <= MAX_AGE; n++) begin
				if (n > 0) begin
					w = longint'((longint'(unsigned'(w)) * longint'(unsigned'(g))) >> 30);
				end
				kernel[n] = ((longint'(unsigned'(n)) * longint'(unsigned'(w)))
				            / longint'(unsigned'(ALPHA_BASE)) + 64'd8192) >> 14;
			end
		endfunction

		function logic signed [31:0] clamp32(longint x);
			logic signed [31:0] r;
			if (x > 64'sh7FFF_FFFF) begin
				r = 32'sh7FFF_FFFF;
			end else if (x < -64'sh8000_0000) begin
				r = 32'sh8000_0000;
			end else begin
				r = x[31:0];
			end
			return r;
		endfunction

		function logic signed [31:0] fxmul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b);
			return clamp32(p >>> 16);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx < NUM_CFG) cfg[idx[2:0]] = data;
		endfunction

		function void note_tick(logic signed [31:0] cur, logic signed [31:0] noise);
			logic signed [31:0] dr;
			logic signed [31:0] dt;
			logic signed [31:0] quad;
			logic signed [31:0] v;
			logic signed [31:0] inner;
			logic signed [31:0] un;
			longint             drive;
			longint unsigned    sum;
			tick_t              r;
			dr = clamp32(longint'(potential) - longint'(cfg[REG_VR]));
			dt = clamp32(longint'(potential) - longint'(cfg[REG_VT]));
			quad = fxmul(cfg[REG_K], fxmul(dr, dt));
			drive = longint'(quad) - longint'(recovery) + longint'(BASELINE_CURRENT)
			        + longint'(cur) + longint'(noise);
			v = clamp32(longint'(potential) + drive / longint'(CAPACITANCE));
			inner = clamp32(longint'(fxmul(cfg[REG_B], dr)) - longint'(recovery));
			un = clamp32(longint'(recovery) + longint'(fxmul(cfg[REG_A], inner)));
			r.spiked = (v >= cfg[REG_VPEAK]);
			if (r.spiked) begin
				potential = cfg[REG_C];
				un = clamp32(longint'(un) + longint'(cfg[REG_D]));
				ages[0] = 1'b1;
			end else begin
				potential = v;
			end
			recovery = un;
			sum = 0;
			for (int i = 0; i <= MAX_AGE; i++) begin
				if (ages[i]) sum += kernel[i];
			end
			if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
			ages = ages << 1;
			r.membrane = v;
			r.recovery = un;
			r.alpha = sum[31:0];
			expected_ticks.push_back(r);
		endfunction

		function void check_tick(logic [95:0] data, logic spk);
			tick_t want;
			if (expected_ticks.size() == 0) begin
				$error("unexpected result transaction: data %h spiked %b", data, spk);
				errors++;
				return;
			end
			want = expected_ticks.pop_front();
			if (data[31:0] !== want.membrane) begin
				$error("membrane: expected %0d, actual %0d", want.membrane, $signed(data[31:0]));
				errors++;
			end
			if (data[63:32] !== want.recovery) begin
				$error("recovery: expected %0d, actual %0d", want.recovery, $signed(data[63:32]));
				errors++;
			end
			if (spk !== want.spiked) begin
				$error("spiked: expected %0b, actual %0b", want.spiked, spk);
				errors++;
			end
			if (data[95:64] !== want.alpha) begin
				$error("alpha_output: expected %0d, actual %0d", want.alpha, data[95:64]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;
	logic [0:0]           m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	int                   cycles = 0;
	logic                 calm;
	logic signed [31:0]   cfg_plan [NUM_CFG];

	tick_scoreboard board = new();

	assign calm = ((cycles / CALM_SPAN) % 5) == 2;

	quadratic_neuron_alpha_output #(
		.ALPHA_BASE      (ALPHA_BASE),
		.MAX_AGE         (MAX_AGE),
		.CAPACITANCE     (CAPACITANCE),
		.BASELINE_CURRENT(BASELINE_CURRENT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_tick(m_axis_tdata, m_axis_tuser[0]);
			if (s_axis_tvalid && s_axis_tready) begin
				board.note_tick(s_axis_tdata[31:0], s_axis_tdata[63:32]);
			end
			if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_tick(logic [31:0] cur, logic [31:0] noise);
		while (!calm && ($urandom_range(0, 99) < 30)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {noise, cur};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.expected_ticks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic plan_phase(int p);
		for (int i = 0; i < NUM_CFG; i++) begin
			case (p)
				0: cfg_plan[i] = CFG_RESET[i];
				1: cfg_plan[i] = 32'sh7FFF_FFFF;
				2: cfg_plan[i] = 32'sh8000_0000;
				3: cfg_plan[i] = '0;
				4: cfg_plan[i] = CFG_RESET[i];
				default: begin
					if ($urandom_range(0, 99) < 20) begin
						cfg_plan[i] = $urandom;
					end else begin
						cfg_plan[i] = CFG_RESET[i] + (CFG_RESET[i] >>> 1)
						              - $signed(($urandom & 32'h7FFF_FFFF)
						              % (32'h7FFF_FFFF & (CFG_RESET[i] < 0 ?
						                 -CFG_RESET[i] : CFG_RESET[i]) + 1));
					end
				end
			endcase
		end
		// A peak far below rest makes the neuron fire on most ticks.
		if (p == 4) cfg_plan[REG_VPEAK] = -32'sd6553600;
	endtask

	task automatic run_phase(int p);
		logic [31:0] base;
		logic [31:0] cur;
		logic [31:0] noise;
		int          sel;
		wait_drained();
		plan_phase(p);
		for (int i = 0; i < NUM_CFG; i++) write_cfg(CFG_IDX_W'(i), cfg_plan[i]);
		if (p == 4) begin
			write_cfg(CFG_IDX_SPARE_LO, $urandom);
			write_cfg(CFG_IDX_SPARE_HI, $urandom);
		end
		cfg_valid <= 1'b0;
		base = '0;
		for (int n = 0; n < PHASE_TICKS; n++) begin
			if (n % 40 == 0) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					base = $urandom_range(0, 150 * 65536);
				end else if (sel < 7) begin
					base = -$urandom_range(0, 60 * 65536);
				end else if (sel < 8) begin
					base = '0;
				end else begin
					base = $urandom;
				end
			end
			if ($urandom_range(0, 99) < 15) begin
				cur = $urandom;
				noise = $urandom;
			end else begin
				cur = base + $urandom_range(0, 131072) - 65536;
				noise = ($urandom_range(0, 1) == 1) ? '0 : $urandom_range(0, 655360) - 327680;
			end
			send_tick(cur, noise);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_tick(32'h0000_0000, 32'h0000_0000);
		send_tick(32'h7FFF_FFFF, 32'h0000_0000);
		send_tick(32'h8000_0000, 32'h0000_0000);
		send_tick(32'h0000_0000, 32'h7FFF_FFFF);
		send_tick(32'h0000_0000, 32'h8000_0000);
		send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_tick(32'h8000_0000, 32'h8000_0000);
		send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_tick(32'h5555_5555, 32'hAAAA_AAAA);
		send_tick(32'hAAAA_AAAA, 32'h5555_5555);
		repeat (10) send_tick(32'd500 << 16, 32'h0000_0000);
		repeat (4) send_tick(32'h0000_0000, 32'd2 << 16);
		for (int p = 0; p < PHASES; p++) run_phase(p);
		wait_drained();
		if (board.errors == 0 && board.expected_ticks.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[sim.f]
src/qnao_pkg.sv
src/qnao_ctrl.sv
src/qnao_datapath.sv
src/quadratic_neuron_alpha_output.sv
tb/sv/testbench.sv
